@@ rtl/core/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// Thermistor temperature smoother package
// Shared widths, the resistance table, queue and divider types, and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TEMP_W     = 10;
    localparam int AVG_W      = 18;
    localparam int RES_BITS   = 24;
    localparam int ENTRY_W    = 18;
    localparam int IDX_W      = 5;
    localparam int TABLE_ENTRIES = 32;
    localparam int NUM_W      = 49;
    localparam int DEN_W      = 29;
    localparam int STEP_W     = 6;
    localparam int PROD_W     = 34;
    localparam int IP_PROD_W  = 29;
    localparam int D10_W      = 21;
    localparam int IP_W       = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [RES_BITS-1:0] RES_MAX = {RES_BITS{1'b1}};
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic signed [TEMP_W-1:0] TEMP_FIRST = -10'sd20;
    localparam logic [STEP_W-1:0] RES_DIV_STEPS = STEP_W'(NUM_W);
    localparam logic [STEP_W-1:0] IP_DIV_STEPS  = STEP_W'(IP_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_OHMS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_MV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SHIFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET   = 3'd4;

    typedef struct packed {
        logic             sat;
        logic [DEN_W-1:0] den;
    } t_q_entry;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [NUM_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_SEARCH,
        ST_IP_MUL,
        ST_IP_GO,
        ST_IP_WAIT,
        ST_FINISH
    } t_back_state;

    // Falling resistance table, entry i stands for -20 + 10*i degrees F.
    function automatic logic [ENTRY_W-1:0] res_entry(input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] v;
        unique case (idx)
            5'd0:  v = 18'd189726;
            5'd1:  v = 18'd132092;
            5'd2:  v = 18'd93425;
            5'd3:  v = 18'd67059;
            5'd4:  v = 18'd48804;
            5'd5:  v = 18'd35983;
            5'd6:  v = 18'd26855;
            5'd7:  v = 18'd20274;
            5'd8:  v = 18'd15473;
            5'd9:  v = 18'd11929;
            5'd10: v = 18'd9287;
            5'd11: v = 18'd7295;
            5'd12: v = 18'd5781;
            5'd13: v = 18'd4618;
            5'd14: v = 18'd3718;
            5'd15: v = 18'd3016;
            5'd16: v = 18'd2463;
            5'd17: v = 18'd2025;
            5'd18: v = 18'd1675;
            5'd19: v = 18'd1395;
            5'd20: v = 18'd1167;
            5'd21: v = 18'd983;
            5'd22: v = 18'd832;
            5'd23: v = 18'd707;
            5'd24: v = 18'd604;
            5'd25: v = 18'd519;
            5'd26: v = 18'd447;
            5'd27: v = 18'd387;
            5'd28: v = 18'd336;
            5'd29: v = 18'd294;
            5'd30: v = 18'd257;
            5'd31: v = 18'd226;
        endcase
        return v;
    endfunction

    function automatic logic signed [TEMP_W-1:0] temp_of_idx(input logic [IDX_W-1:0] idx);
        logic [TEMP_W-1:0] t10;
        t10 = {2'b00, idx, 3'b000} + {4'b0000, idx, 1'b0};
        return $signed(t10) + TEMP_FIRST;
    endfunction

endpackage

@@ rtl/core/tts_front.sv @@
// ----------------------------------------------------------------------------
// Thermistor smoother front end
// Takes converter samples, sorts out the ones that saturate the resistance
// and forms the divisor sample * full scale for the back end.
// ----------------------------------------------------------------------------
module tts_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [13:0]                        i_full_scale_mv,
    input  logic                               i_q_full,
    output logic                               o_push,
    output tts_pkg::t_q_entry                  o_entry
);

    logic                               r_valid;
    logic signed [tts_pkg::SAMPLE_W-1:0] r_sample;

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || o_push;

    // A sample at or below zero, or a zero full scale, gives the top resistance.
    assign o_entry.sat = r_sample[tts_pkg::SAMPLE_W-1] || (r_sample == '0)
                         || (i_full_scale_mv == '0);
    assign o_entry.den = tts_pkg::DEN_W'(r_sample[tts_pkg::SAMPLE_W-2:0])
                         * tts_pkg::DEN_W'(i_full_scale_mv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sample <= i_sample;
        end
    end

endmodule

@@ rtl/core/tts_queue.sv @@
// ----------------------------------------------------------------------------
// Thermistor smoother queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tts_pkg::t_q_entry i_entry,
    input  logic              i_pop,
    output tts_pkg::t_q_entry o_entry,
    output logic              o_full,
    output logic              o_empty
);

    tts_pkg::t_q_entry r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ rtl/core/tts_div.sv @@
// ----------------------------------------------------------------------------
// Thermistor smoother divider
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// resistance calculation and the interpolation.
// ----------------------------------------------------------------------------
module tts_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tts_pkg::t_div_req i_req,
    output tts_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [tts_pkg::STEP_W-1:0]  r_cnt;
    logic [tts_pkg::DEN_W-1:0]   r_rem;
    logic [tts_pkg::DEN_W-1:0]   r_div;
    logic [tts_pkg::NUM_W-1:0]   r_work;

    logic [tts_pkg::DEN_W:0]     rem_sh;
    logic [tts_pkg::DEN_W:0]     rem_sub;
    logic                        ge;

    // The dividend sits at the top of the work register; quotient bits fill in
    // from the bottom, so after the given number of steps it holds the quotient.
    assign rem_sh  = {r_rem, r_work[tts_pkg::NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign ge      = (rem_sh >= {1'b0, r_div});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tts_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_work <= i_req.dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[tts_pkg::DEN_W-1:0] : rem_sh[tts_pkg::DEN_W-1:0];
            r_work <= {r_work[tts_pkg::NUM_W-2:0], ge};
        end
    end

endmodule

@@ rtl/core/tts_back.sv @@
// ----------------------------------------------------------------------------
// Thermistor smoother back end
// Sequencer that finds the resistance, searches the table, interpolates,
// updates the exponential average and holds the result for the output.
// ----------------------------------------------------------------------------
module tts_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [19:0]                        i_bias_ohms,
    input  logic [13:0]                        i_supply_mv,
    input  logic [2:0]                         i_smooth_shift,
    input  logic signed [4:0]                  i_temp_offset,
    input  logic                               i_q_empty,
    input  tts_pkg::t_q_entry                  i_entry,
    output logic                               o_pop,
    output tts_pkg::t_div_req                  o_div_req,
    input  tts_pkg::t_div_rsp                  i_div_rsp,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [tts_pkg::TEMP_W-1:0]  o_temp_smoothed,
    output logic signed [tts_pkg::TEMP_W-1:0]  o_temp_raw
);

    tts_pkg::t_back_state r_state;
    tts_pkg::t_back_state n_state;

    logic [tts_pkg::DEN_W-1:0]            r_den;
    logic [tts_pkg::PROD_W-1:0]           r_prod;
    logic [tts_pkg::RES_BITS-1:0]         r_res;
    logic [tts_pkg::IDX_W-1:0]            r_idx;
    logic signed [tts_pkg::IP_PROD_W-1:0] r_ip_prod;
    logic [tts_pkg::D10_W-1:0]            r_d10;
    logic [tts_pkg::ENTRY_W-1:0]          r_span;
    logic                                 r_neg;
    logic signed [tts_pkg::TEMP_W-1:0]    r_raw;
    logic signed [tts_pkg::AVG_W-1:0]     r_avg;
    logic                                 r_out_valid;
    logic signed [tts_pkg::TEMP_W-1:0]    r_out_smooth;
    logic signed [tts_pkg::TEMP_W-1:0]    r_out_raw;

    logic                                 out_free;
    logic                                 load_out;
    logic signed [tts_pkg::TEMP_W-1:0]    off_ext;
    logic [tts_pkg::ENTRY_W-1:0]          entry_cur;
    logic [tts_pkg::ENTRY_W-1:0]          entry_prev;
    logic                                 hit;
    logic [tts_pkg::NUM_W-1:0]            num;
    logic [tts_pkg::NUM_W-1:0]            q_full;
    logic [tts_pkg::NUM_W-1:0]            bias_ext;
    logic [tts_pkg::NUM_W-1:0]            q_minus;
    logic [tts_pkg::RES_BITS-1:0]         res_from_q;
    logic signed [tts_pkg::TEMP_W-1:0]    hi_t;
    logic signed [tts_pkg::IP_PROD_W-1:0] hi_ext;
    logic signed [tts_pkg::IP_PROD_W-1:0] span_ext;
    logic [tts_pkg::ENTRY_W-1:0]          d;
    logic signed [29:0]                   n_val;
    logic [29:0]                          n_mag;
    logic [tts_pkg::TEMP_W-1:0]           q_ip;
    logic signed [tts_pkg::TEMP_W-1:0]    raw_ip;
    logic signed [tts_pkg::AVG_W:0]       target;
    logic signed [tts_pkg::AVG_W:0]       avg_ext;
    logic signed [tts_pkg::AVG_W:0]       diff;
    logic signed [tts_pkg::AVG_W:0]       avg_step;
    logic signed [tts_pkg::AVG_W:0]       avg_new;

    assign out_free = !r_out_valid || i_ready;
    assign load_out = (r_state == tts_pkg::ST_FINISH) && out_free;

    assign off_ext    = tts_pkg::TEMP_W'(i_temp_offset);
    assign entry_cur  = tts_pkg::res_entry(r_idx);
    assign entry_prev = tts_pkg::res_entry(r_idx - 1'b1);
    assign hit        = r_res > tts_pkg::RES_BITS'(entry_cur);

    // supply * bias * 32767 as (x << 15) - x.
    assign num = {r_prod, 15'b0} - tts_pkg::NUM_W'(r_prod);

    assign q_full     = i_div_rsp.quotient;
    assign bias_ext   = tts_pkg::NUM_W'(i_bias_ohms);
    assign q_minus    = q_full - bias_ext;
    always_comb begin
        if (q_full < bias_ext) begin
            res_from_q = '0;
        end else if (q_minus > tts_pkg::NUM_W'(tts_pkg::RES_MAX)) begin
            res_from_q = tts_pkg::RES_MAX;
        end else begin
            res_from_q = q_minus[tts_pkg::RES_BITS-1:0];
        end
    end

    // Interpolation: ((hi_t + off) * span - 10 * d) / span, truncated toward zero.
    assign hi_t     = tts_pkg::temp_of_idx(r_idx) + off_ext;
    assign hi_ext   = tts_pkg::IP_PROD_W'(hi_t);
    assign span_ext = $signed(tts_pkg::IP_PROD_W'(entry_prev - entry_cur));
    assign d        = r_res[tts_pkg::ENTRY_W-1:0] - entry_cur;
    assign n_val    = 30'(r_ip_prod) - $signed({9'b0, r_d10});
    assign n_mag    = n_val[29] ? 30'(-n_val) : 30'(n_val);
    assign q_ip     = i_div_rsp.quotient[tts_pkg::TEMP_W-1:0];
    assign raw_ip   = r_neg ? $signed(-q_ip) : $signed(q_ip);

    // Average update; the arithmetic shift rounds toward minus infinity.
    assign target   = {r_raw[tts_pkg::TEMP_W-1], r_raw, 8'b0};
    assign avg_ext  = (tts_pkg::AVG_W + 1)'(r_avg);
    assign diff     = target - avg_ext;
    assign avg_step = diff >>> i_smooth_shift;
    assign avg_new  = avg_ext + avg_step;

    always_comb begin
        n_state            = r_state;
        o_pop              = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.steps    = tts_pkg::RES_DIV_STEPS;
        o_div_req.dividend = num;
        o_div_req.divisor  = r_den;
        unique case (r_state)
            tts_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_entry.sat ? tts_pkg::ST_SEARCH : tts_pkg::ST_MUL;
                end
            end
            tts_pkg::ST_MUL: begin
                n_state = tts_pkg::ST_RDIV_GO;
            end
            tts_pkg::ST_RDIV_GO: begin
                o_div_req.start = 1'b1;
                n_state         = tts_pkg::ST_RDIV_WAIT;
            end
            tts_pkg::ST_RDIV_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = tts_pkg::ST_SEARCH;
                end
            end
            tts_pkg::ST_SEARCH: begin
                if (hit) begin
                    n_state = (r_idx == '0) ? tts_pkg::ST_FINISH : tts_pkg::ST_IP_MUL;
                end else if (r_idx == tts_pkg::IDX_LAST) begin
                    n_state = tts_pkg::ST_FINISH;
                end
            end
            tts_pkg::ST_IP_MUL: begin
                n_state = tts_pkg::ST_IP_GO;
            end
            tts_pkg::ST_IP_GO: begin
                o_div_req.start    = 1'b1;
                o_div_req.steps    = tts_pkg::IP_DIV_STEPS;
                o_div_req.dividend = {n_mag[tts_pkg::IP_W-1:0],
                                      {(tts_pkg::NUM_W - tts_pkg::IP_W){1'b0}}};
                o_div_req.divisor  = tts_pkg::DEN_W'(r_span);
                n_state            = tts_pkg::ST_IP_WAIT;
            end
            tts_pkg::ST_IP_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = tts_pkg::ST_FINISH;
                end
            end
            tts_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = tts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_avg       <= avg_new[tts_pkg::AVG_W-1:0];
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_smooth <= avg_new[tts_pkg::AVG_W-1:8];
            r_out_raw    <= r_raw;
        end
        unique case (r_state)
            tts_pkg::ST_IDLE: begin
                r_den <= i_entry.den;
                r_res <= tts_pkg::RES_MAX;
                r_idx <= '0;
            end
            tts_pkg::ST_MUL: begin
                r_prod <= tts_pkg::PROD_W'(i_supply_mv) * tts_pkg::PROD_W'(i_bias_ohms);
            end
            tts_pkg::ST_RDIV_WAIT: begin
                if (i_div_rsp.done) begin
                    r_res <= res_from_q;
                end
            end
            tts_pkg::ST_SEARCH: begin
                if (hit) begin
                    if (r_idx == '0) begin
                        r_raw <= tts_pkg::TEMP_FIRST + off_ext;
                    end
                end else if (r_idx == tts_pkg::IDX_LAST) begin
                    r_raw <= tts_pkg::temp_of_idx(tts_pkg::IDX_LAST) + off_ext;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            tts_pkg::ST_IP_MUL: begin
                r_ip_prod <= hi_ext * span_ext;
                r_d10     <= {d, 3'b000} + {2'b00, d, 1'b0};
                r_span    <= entry_prev - entry_cur;
            end
            tts_pkg::ST_IP_GO: begin
                r_neg <= n_val[29];
            end
            tts_pkg::ST_IP_WAIT: begin
                if (i_div_rsp.done) begin
                    r_raw <= raw_ip;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_temp_smoothed = r_out_smooth;
    assign o_temp_raw      = r_out_raw;

endmodule

@@ rtl/core/thermistor_temperature_smoother.sv @@
// ----------------------------------------------------------------------------
// Thermistor temperature smoother
// Converts a divider sample to thermistor resistance, interpolates the
// temperature from a table and smooths it with an exponential average.
// ----------------------------------------------------------------------------
// The shared one-bit-per-cycle divider (49 steps for resistance, 24 for interpolation)
// and the table search at one entry per cycle (up to 32) set the time from input
// transaction to output valid.
// Samples at or below zero, or a zero full scale, skip the divisions.
// One item is processed at a time; three more can wait.
// Synchronous reset clears control state, the average and the registers to defaults.
module thermistor_temperature_smoother (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [15:0]                        i_s_axis_tdata,  // [15:0] adc_sample
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [23:0]                        o_m_axis_tdata,  // [9:0] temp_smoothed,
                                                                // [19:10] temp_raw
    input  logic                               i_cfg_we,
    input  logic [tts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [19:0]       r_bias_ohms;
    logic [13:0]       r_supply_mv;
    logic [13:0]       r_full_scale_mv;
    logic [2:0]        r_smooth_shift;
    logic signed [4:0] r_temp_offset;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    tts_pkg::t_q_entry q_wr_entry;
    tts_pkg::t_q_entry q_rd_entry;
    tts_pkg::t_div_req div_req;
    tts_pkg::t_div_rsp div_rsp;

    logic signed [tts_pkg::TEMP_W-1:0] temp_smoothed;
    logic signed [tts_pkg::TEMP_W-1:0] temp_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_ohms     <= 20'd3000;
            r_supply_mv     <= 14'd4960;
            r_full_scale_mv <= 14'd6144;
            r_smooth_shift  <= 3'd1;
            r_temp_offset   <= 5'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tts_pkg::CFG_BIAS_OHMS:     r_bias_ohms     <= i_cfg_data[19:0];
                tts_pkg::CFG_SUPPLY_MV:     r_supply_mv     <= i_cfg_data[13:0];
                tts_pkg::CFG_FULL_SCALE_MV: r_full_scale_mv <= i_cfg_data[13:0];
                tts_pkg::CFG_SMOOTH_SHIFT:  r_smooth_shift  <= i_cfg_data[2:0];
                tts_pkg::CFG_TEMP_OFFSET:   r_temp_offset   <= $signed(i_cfg_data[4:0]);
                default: begin
                end
            endcase
        end
    end

    tts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_sample        ($signed(i_s_axis_tdata)),
        .i_full_scale_mv (r_full_scale_mv),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_entry         (q_wr_entry)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bias_ohms     (r_bias_ohms),
        .i_supply_mv     (r_supply_mv),
        .i_smooth_shift  (r_smooth_shift),
        .i_temp_offset   (r_temp_offset),
        .i_q_empty       (q_empty),
        .i_entry         (q_rd_entry),
        .o_pop           (q_pop),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_temp_smoothed (temp_smoothed),
        .o_temp_raw      (temp_raw)
    );

    assign o_m_axis_tdata = {4'b0000, temp_raw, temp_smoothed};

    // The queue is never written while full nor read while empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // Reset leaves no result pending on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

@@ tb/tb_thermistor_temperature_smoother.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Thermistor temperature smoother testbench
// Streams converter codes into the smoother and checks every averaged and raw
// temperature it returns against a cycle-free model of the divider equation,
// the table interpolation and the exponential average. The run covers directed
// table points, register extremes, random settings, random idling on both
// streams and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_thermistor_temperature_smoother;

    localparam int TEMP_W          = tts_pkg::TEMP_W;
    localparam int RES_BITS        = tts_pkg::RES_BITS;
    localparam int TABLE_ENTRIES   = tts_pkg::TABLE_ENTRIES;
    localparam int CFG_IDX_W       = tts_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = tts_pkg::CFG_DATA_W;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 150;
    localparam int MAX_GAP         = 11;
    localparam int ITEMS_PER_PHASE = 110;
    localparam longint unsigned CODE_FULL  = 32767;
    localparam longint unsigned OHMS_SAT   = (64'd1 << RES_BITS) - 1;
    localparam int TEMP_STEP   = 10;
    localparam int TEMP_COLD   = -20;
    localparam int TEMP_HOT    = TEMP_COLD + TEMP_STEP * (TABLE_ENTRIES - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        CFG_IDX_W'(tts_pkg::CFG_TEMP_OFFSET + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    typedef struct {
        logic signed [TEMP_W-1:0] smoothed;
        logic signed [TEMP_W-1:0] raw;
    } t_temp_pair;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata = '0;  // [15:0] adc_sample
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;       // [9:0] temp_smoothed, [19:10] temp_raw
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Falling thermistor resistance in ohms, entry i at -20 + 10*i degrees F.
    int unsigned ohms_table [TABLE_ENTRIES] = '{
        189726, 132092, 93425, 67059, 48804, 35983, 26855, 20274,
        15473, 11929, 9287, 7295, 5781, 4618, 3718, 3016,
        2463, 2025, 1675, 1395, 1167, 983, 832, 707,
        604, 519, 447, 387, 336, 294, 257, 226
    };

    // Model copy of the registers and the average, at their reset values.
    int unsigned bias_res  = 3000;
    int unsigned supply    = 4960;
    int unsigned adc_fs    = 6144;
    int unsigned avg_shift = 1;
    int          deg_offset = 0;
    longint      avg_q8 = 0;

    t_temp_pair  temp_expect_q [$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          quiet_cycles = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          sink_hold = 0;
    int          stall_reqs = 0;
    int          stall_seen = 0;
    logic        idle_mode = 1'b0;

    thermistor_temperature_smoother uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_gap();
        return idle_mode ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Mostly positive codes spread over all octaves so that every table
    // interval is reached, with some fully random codes mixed in.
    function automatic logic [15:0] draw_code();
        int octave;
        if ($urandom_range(0, 7) == 0) begin
            return 16'($urandom);
        end
        octave = $urandom_range(0, 14);
        return 16'((1 << octave) | ($urandom & ((1 << octave) - 1)));
    endfunction

    // Resistance from the divider, table interpolation and the running average.
    function automatic t_temp_pair predict_temperature(input logic [15:0] code);
        logic signed [15:0] sample;
        longint unsigned    num;
        longint unsigned    den;
        longint unsigned    ohms;
        longint             hi_t;
        longint             d;
        longint             span;
        longint             n;
        longint             raw;
        longint             delta;
        bit                 found;
        t_temp_pair         res;
        sample = code;
        if (sample <= 0 || adc_fs == 0) begin
            ohms = OHMS_SAT;
        end else begin
            num = longint'(supply) * longint'(bias_res) * CODE_FULL;
            den = longint'(code) * longint'(adc_fs);
            ohms = num / den;
            if (ohms < bias_res) begin
                ohms = 0;
            end else begin
                ohms = ohms - bias_res;
                if (ohms > OHMS_SAT) ohms = OHMS_SAT;
            end
        end
        raw = TEMP_HOT + deg_offset;
        found = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES && !found; i++) begin
            if (ohms > ohms_table[i]) begin
                found = 1'b1;
                if (i == 0) begin
                    raw = TEMP_COLD + deg_offset;
                end else begin
                    hi_t = TEMP_COLD + TEMP_STEP * i;
                    d = longint'(ohms) - longint'(ohms_table[i]);
                    span = longint'(ohms_table[i-1]) - longint'(ohms_table[i]);
                    n = (hi_t + deg_offset) * span - TEMP_STEP * d;
                    // Integer division truncates toward zero here.
                    raw = n / span;
                end
            end
        end
        delta = raw * 256 - avg_q8;
        avg_q8 = avg_q8 + (delta >>> avg_shift);
        res.smoothed = TEMP_W'(avg_q8 >>> 8);
        res.raw = TEMP_W'(raw);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    // Output side: random stalls, a long hold on request, and the checks.
    always @(posedge i_clk) begin
        t_temp_pair               want;
        logic signed [TEMP_W-1:0] got_smoothed;
        logic signed [TEMP_W-1:0] got_raw;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_smoothed = o_m_axis_tdata[9:0];
                got_raw = o_m_axis_tdata[19:10];
                if (temp_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result smoothed %0d raw %0d",
                                              got_smoothed, got_raw));
                end else begin
                    want = temp_expect_q.pop_front();
                    if (got_smoothed !== want.smoothed)
                        report_mismatch($sformatf("temp_smoothed got %0d expected %0d",
                                                  got_smoothed, want.smoothed));
                    if (got_raw !== want.raw)
                        report_mismatch($sformatf("temp_raw got %0d expected %0d",
                                                  got_raw, want.raw));
                end
                result_count++;
                sink_gap = draw_gap();
            end else if (sink_gap > 0) begin
                sink_gap--;
            end
            if (stall_seen != stall_reqs) begin
                stall_seen = stall_reqs;
                sink_hold = HOLD_CYCLES;
            end else if (sink_hold > 0) begin
                sink_hold--;
            end
            i_m_axis_tready <= (sink_gap == 0 && sink_hold == 0);
        end
    end

    // Ends the run when neither stream moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("TIMEOUT after %0d quiet cycles, %0d results pending",
                         quiet_cycles, temp_expect_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic feed_sample(input logic [15:0] code);
        if (src_gap > 0) repeat (src_gap) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= code;
        do @(posedge i_clk); while (!o_s_axis_tready);
        temp_expect_q.push_back(predict_temperature(code));
        // Valid stays high when the next transaction follows back to back.
        src_gap = draw_gap();
        if (src_gap != 0) i_s_axis_tvalid <= 1'b0;
    endtask

    // Stops the input stream and waits until the block has nothing in flight.
    task automatic wait_idle();
        if (src_gap == 0) i_s_axis_tvalid <= 1'b0;
        src_gap = 0;
        @(posedge i_clk);
        while (temp_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned bias, input int unsigned mv,
                                  input int unsigned fs, input int unsigned shift,
                                  input int offset);
        logic [4:0] off_bits;
        off_bits = offset[4:0];
        wait_idle();
        write_reg(tts_pkg::CFG_BIAS_OHMS, CFG_DATA_W'(bias));
        write_reg(tts_pkg::CFG_SUPPLY_MV, CFG_DATA_W'(mv));
        write_reg(tts_pkg::CFG_FULL_SCALE_MV, CFG_DATA_W'(fs));
        write_reg(tts_pkg::CFG_SMOOTH_SHIFT, CFG_DATA_W'(shift));
        write_reg(tts_pkg::CFG_TEMP_OFFSET, {{(CFG_DATA_W-5){1'b0}}, off_bits});
        // A write to an index past the register list must change nothing.
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        bias_res = bias;
        supply = mv;
        adc_fs = fs;
        avg_shift = shift;
        deg_offset = offset;
    endtask

    // Default settings: walks the table from saturated resistance to shorted
    // input, including the last interval, truncation of negative temperatures
    // and samples above the supply voltage.
    task automatic test_table_walk();
        logic [15:0] codes [$];
        idle_mode <= 1'b1;
        codes = '{16'h0000, 16'h8000, 16'hFFFF, 16'd1, 16'd200, 16'd411, 16'd412,
                  16'd500, 16'd587, 16'd1000, 16'd5000, 16'd12000, 16'd24366,
                  16'd24500, 16'd24600, 16'd25000, 16'd26454, 16'h7FFF};
        foreach (codes[i]) feed_sample(codes[i]);
    endtask

    // Smallest register values, large register values, and a zero full scale.
    task automatic test_register_extremes();
        apply_settings(1, 1, 1, 0, -16);
        feed_sample(16'd1);
        feed_sample(16'h5555);
        apply_settings(1000000, 10000, 10000, 7, 15);
        feed_sample(16'd1);
        feed_sample(16'd300);
        feed_sample(16'hAAAA);
        apply_settings(3000, 4960, 0, 1, 0);
        feed_sample(16'd1000);
    endtask

    task automatic test_random_settings(input bit keep_defaults, input bit idling);
        if (keep_defaults)
            apply_settings(3000, 4960, 6144, 1, 0);
        else
            apply_settings($urandom_range(1, 1000000), $urandom_range(1, 10000),
                           $urandom_range(1, 10000), $urandom_range(0, 7),
                           int'($urandom_range(0, 31)) - 16);
        idle_mode <= idling;
        repeat (ITEMS_PER_PHASE) feed_sample(draw_code());
    endtask

    // The output is held off for a long stretch while input keeps coming, so
    // the input stage and queue fill and the input stalls.
    task automatic test_output_stall();
        apply_settings(3000, 4960, 6144, 2, -5);
        idle_mode <= 1'b0;
        stall_reqs <= stall_reqs + 1;
        repeat (24) feed_sample(draw_code());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_walk();
        test_register_extremes();
        test_random_settings(1'b1, 1'b1);
        test_random_settings(1'b0, 1'b1);
        test_random_settings(1'b0, 1'b0);
        test_output_stall();
        test_random_settings(1'b0, 1'b1);
        test_random_settings(1'b0, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (temp_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", temp_expect_q.size()));
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
